// File: sv/urbx_pkg.sv
// shared types and constants for the uart ring buffer / xon-xoff engine
// item and result payload structs, command and flow-state codes
// no dependencies
package urbx_pkg;

    localparam int RX_DEPTH_DEFAULT = 256;
    localparam int TX_DEPTH_DEFAULT = 256;

    localparam logic [7:0] XOFF_THR_RESET = 8'd250;
    localparam logic [7:0] XON_THR_RESET  = 8'd230;

    localparam logic [7:0] CHAR_XOFF = 8'h13;
    localparam logic [7:0] CHAR_XON  = 8'h11;

    localparam logic [2:0] CMD_RX_BYTE    = 3'd0;
    localparam logic [2:0] CMD_TX_READY   = 3'd1;
    localparam logic [2:0] CMD_HOST_WRITE = 3'd2;
    localparam logic [2:0] CMD_HOST_READ  = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;

    localparam logic [1:0] FLOW_XON_SENT     = 2'd0;
    localparam logic [1:0] FLOW_XOFF_PENDING = 2'd1;
    localparam logic [1:0] FLOW_XOFF_SENT    = 2'd2;
    localparam logic [1:0] FLOW_XON_PENDING  = 2'd3;

    localparam logic REG_XOFF_THR = 1'b0;
    localparam logic REG_XON_THR  = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       framing_error;
        logic       overrun_error;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       framing_seen;
        logic       overrun_seen;
        logic       rx_overflow;
        logic       tx_overflow;
        logic [7:0] rx_free;
        logic [7:0] tx_free;
        logic [1:0] flow_state;
        logic       remote_paused;
    } result_t;

endpackage

// File: sv/urbx_ring.sv
// byte ring: memory, read and write pointers, free count, registered read data
// one slot always stays empty; depends on nothing outside this file
module urbx_ring #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [7:0]               push_data,
    input  logic                     pop,
    output logic [7:0]               rd_data,
    output logic [$clog2(DEPTH)-1:0] free,
    output logic                     empty
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [7:0]    rd_data_reg;

    assign wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
    assign rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);

    always_comb
    begin
        if (rd_ptr_reg > wr_ptr_reg)
        begin
            free = rd_ptr_reg - wr_ptr_reg - AW'(1);
        end
        else
        begin
            free = LAST - wr_ptr_reg + rd_ptr_reg;
        end
    end

    assign empty   = (rd_ptr_reg == wr_ptr_reg);
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // read data holds until the next pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// File: sv/uart_ring_buffers_xon_xoff.sv
// top level of the uart ring buffer and xon/xoff flow-control engine
// depends on urbx_pkg and urbx_ring (one instance per direction)
//
// usage:
//   item channel (item_valid/item_ready/item) carries one event: a received
//   byte with its error bits, transmitter ready, host write, host read or
//   clear errors. result channel (result_valid/result_ready/result) returns
//   one status word per event: the byte sent or popped, sticky error flags,
//   free space of both rings, flow state and remote pause.
//   the result of an item is valid in the cycle after its transfer. one item
//   per cycle is taken while result_ready stays high; the rate is set by the
//   single result register and the registered memory read of each ring.
//   when the receiver stalls, the result register holds and item_ready
//   drops until the result transfer completes.
//   reset clears the ring pointers, flow state, pause and error flags and
//   loads the thresholds with 250 (xoff) and 230 (xon); no clearing pass.
//   thresholds are written over the apb port at 0x0 (xoff) and 0x4 (xon).
module uart_ring_buffers_xon_xoff #(
    parameter int RX_DEPTH = urbx_pkg::RX_DEPTH_DEFAULT,
    parameter int TX_DEPTH = urbx_pkg::TX_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  urbx_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output urbx_pkg::result_t result
);

    localparam int RX_CW = $clog2(RX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH);

    logic [7:0] xoff_thr_reg;
    logic [7:0] xon_thr_reg;
    logic       cfg_write;

    logic       accept;
    logic       result_valid_reg;

    logic [1:0] flow_reg;
    logic [1:0] flow_next;
    logic       paused_reg;
    logic       paused_next;
    logic [3:0] err_reg;      // framing, overrun, rx overflow, tx overflow
    logic [3:0] err_next;

    logic       tx_valid_reg;
    logic       tx_valid_next;
    logic       tx_mem_reg;
    logic       tx_mem_next;
    logic [7:0] tx_fix_reg;
    logic [7:0] tx_fix_next;
    logic       read_valid_reg;
    logic       read_valid_next;

    logic             rx_push;
    logic             rx_pop;
    logic             tx_push;
    logic             tx_pop;
    logic [7:0]       rx_rd_data;
    logic [7:0]       tx_rd_data;
    logic [RX_CW-1:0] rx_free;
    logic [TX_CW-1:0] tx_free;
    logic             rx_empty;
    logic             tx_empty;

    logic [RX_CW+7:0] rx_free_ext;
    logic [TX_CW+7:0] tx_free_ext;
    logic             rx_big;
    logic             tx_big;
    logic [7:0]       rx_free_sat;
    logic [7:0]       tx_free_sat;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == urbx_pkg::REG_XON_THR) ? {24'b0, xon_thr_reg}
                                                           : {24'b0, xoff_thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xoff_thr_reg <= urbx_pkg::XOFF_THR_RESET;
            xon_thr_reg  <= urbx_pkg::XON_THR_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == urbx_pkg::REG_XON_THR)
            begin
                xon_thr_reg <= pwdata[7:0];
            end
            else
            begin
                xoff_thr_reg <= pwdata[7:0];
            end
        end
    end

    // free counts saturated at 255; big flag keeps the full-value compare
    assign rx_free_ext = {8'b0, rx_free};
    assign tx_free_ext = {8'b0, tx_free};
    assign rx_big      = |(rx_free_ext >> 8);
    assign tx_big      = |(tx_free_ext >> 8);
    assign rx_free_sat = rx_big ? 8'hFF : rx_free_ext[7:0];
    assign tx_free_sat = tx_big ? 8'hFF : tx_free_ext[7:0];

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        flow_next       = flow_reg;
        paused_next     = paused_reg;
        err_next        = err_reg;
        tx_valid_next   = 1'b0;
        tx_mem_next     = 1'b0;
        tx_fix_next     = 8'h00;
        read_valid_next = 1'b0;
        rx_push         = 1'b0;
        rx_pop          = 1'b0;
        tx_push         = 1'b0;
        tx_pop          = 1'b0;
        unique case (item.command)
            urbx_pkg::CMD_RX_BYTE:
            begin
                err_next[0] = err_reg[0] | item.framing_error;
                err_next[1] = err_reg[1] | item.overrun_error;
                if (flow_reg == urbx_pkg::FLOW_XON_SENT && !rx_big
                    && rx_free_sat < xoff_thr_reg)
                begin
                    flow_next = urbx_pkg::FLOW_XOFF_PENDING;
                end
                priority if (item.data_byte == urbx_pkg::CHAR_XOFF)
                begin
                    paused_next = 1'b1;
                end
                else if (item.data_byte == urbx_pkg::CHAR_XON)
                begin
                    paused_next = 1'b0;
                end
                else if (rx_free == '0)
                begin
                    err_next[2] = 1'b1;
                end
                else
                begin
                    rx_push = accept;
                end
            end
            urbx_pkg::CMD_TX_READY:
            begin
                priority if (flow_reg == urbx_pkg::FLOW_XOFF_PENDING)
                begin
                    tx_valid_next = 1'b1;
                    tx_fix_next   = urbx_pkg::CHAR_XOFF;
                    flow_next     = urbx_pkg::FLOW_XOFF_SENT;
                end
                else if (flow_reg == urbx_pkg::FLOW_XON_PENDING)
                begin
                    tx_valid_next = 1'b1;
                    tx_fix_next   = urbx_pkg::CHAR_XON;
                    flow_next     = urbx_pkg::FLOW_XON_SENT;
                end
                else if (!tx_empty && !paused_reg)
                begin
                    tx_valid_next = 1'b1;
                    tx_mem_next   = 1'b1;
                    tx_pop        = accept;
                end
                else
                begin
                    tx_valid_next = 1'b0;
                end
            end
            urbx_pkg::CMD_HOST_WRITE:
            begin
                // writes are dropped while tx overflow stands
                if (!err_reg[3])
                begin
                    if (tx_free == '0)
                    begin
                        err_next[3] = 1'b1;
                    end
                    else
                    begin
                        tx_push = accept;
                    end
                end
            end
            urbx_pkg::CMD_HOST_READ:
            begin
                if (flow_reg == urbx_pkg::FLOW_XOFF_SENT
                    && (rx_big || rx_free_sat > xon_thr_reg))
                begin
                    flow_next = urbx_pkg::FLOW_XON_PENDING;
                end
                if (!rx_empty)
                begin
                    read_valid_next = 1'b1;
                    rx_pop          = accept;
                end
            end
            urbx_pkg::CMD_CLEAR:
            begin
                err_next = 4'b0;
            end
            default:
            begin
                flow_next = flow_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            flow_reg         <= urbx_pkg::FLOW_XON_SENT;
            paused_reg       <= 1'b0;
            err_reg          <= 4'b0;
            tx_valid_reg     <= 1'b0;
            tx_mem_reg       <= 1'b0;
            read_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                result_valid_reg <= 1'b1;
                flow_reg         <= flow_next;
                paused_reg       <= paused_next;
                err_reg          <= err_next;
                tx_valid_reg     <= tx_valid_next;
                tx_mem_reg       <= tx_mem_next;
                read_valid_reg   <= read_valid_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_fix_reg <= tx_fix_next;
        end
    end

    urbx_ring #(
        .DEPTH(RX_DEPTH)
    ) u_rx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rx_push),
        .push_data (item.data_byte),
        .pop       (rx_pop),
        .rd_data   (rx_rd_data),
        .free      (rx_free),
        .empty     (rx_empty)
    );

    urbx_ring #(
        .DEPTH(TX_DEPTH)
    ) u_tx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tx_push),
        .push_data (item.data_byte),
        .pop       (tx_pop),
        .rd_data   (tx_rd_data),
        .free      (tx_free),
        .empty     (tx_empty)
    );

    // state registers already hold the post-transfer values of the result
    assign result_valid         = result_valid_reg;
    assign result.tx_valid      = tx_valid_reg;
    assign result.tx_byte       = tx_mem_reg ? tx_rd_data : tx_fix_reg;
    assign result.read_valid    = read_valid_reg;
    assign result.read_byte     = read_valid_reg ? rx_rd_data : 8'h00;
    assign result.framing_seen  = err_reg[0];
    assign result.overrun_seen  = err_reg[1];
    assign result.rx_overflow   = err_reg[2];
    assign result.tx_overflow   = err_reg[3];
    assign result.rx_free       = rx_free_sat;
    assign result.tx_free       = tx_free_sat;
    assign result.flow_state    = flow_reg;
    assign result.remote_paused = paused_reg;

endmodule

// File: tb/sv/tb_top.sv
// testbench for uart_ring_buffers_xon_xoff: directed table, then random bursts
// local predictor of both rings, sticky flags and xon/xoff flow, checked per result
// depends on urbx_pkg and the uart_ring_buffers_xon_xoff rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urbx_pkg::*;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int BURST_RX    = 0;
    localparam int BURST_TXRDY = 1;
    localparam int BURST_WRITE = 2;
    localparam int BURST_READ  = 3;
    localparam int BURST_MIX   = 4;

    localparam int RANDOM_ITEMS = 1850;
    localparam int N_PHASES     = 7;
    localparam int STALL_LIMIT  = 200;

    typedef struct {
        item_t   ev;
        bit      known;
        result_t status;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    // predictor state
    logic [7:0] rx_mem [256];
    logic [7:0] tx_mem [256];
    logic [7:0] rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
    logic [1:0] flow = FLOW_XON_SENT;
    logic       remote_hold = 1'b0;
    logic       seen_framing = 1'b0, seen_overrun = 1'b0;
    logic       rx_dropped = 1'b0, tx_dropped = 1'b0;
    logic [7:0] thr_xoff = XOFF_THR_RESET;
    logic [7:0] thr_xon = XON_THR_RESET;

    result_t  pending_status [$];
    dir_row_t dir_rows [$];

    int mismatches = 0;
    int n_events = 0, n_results = 0, n_settings = 0;
    int n_xoff = 0, n_xon = 0, n_rx_drop = 0, n_tx_drop = 0, n_popped = 0;
    int gap_max = 6, stall_max = 6;
    int stall_left = 0;
    int quiet_cycles = 0;

    uart_ring_buffers_xon_xoff i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic result_t predict_status(input item_t it);
        result_t    r;
        logic [7:0] fr;
        logic [7:0] nxt;
        r = '0;
        case (it.command)
            CMD_RX_BYTE:
            begin
                if (it.framing_error) seen_framing = 1'b1;
                if (it.overrun_error) seen_overrun = 1'b1;
                // threshold uses free space before the byte lands
                fr = rx_rd - rx_wr - 8'd1;
                if (flow == FLOW_XON_SENT && fr < thr_xoff) flow = FLOW_XOFF_PENDING;
                if (it.data_byte == CHAR_XOFF) remote_hold = 1'b1;
                else if (it.data_byte == CHAR_XON) remote_hold = 1'b0;
                else if (fr == 8'd0)
                begin
                    rx_dropped = 1'b1;
                    n_rx_drop++;
                end
                else
                begin
                    rx_mem[rx_wr] = it.data_byte;
                    rx_wr = rx_wr + 8'd1;
                end
            end
            CMD_TX_READY:
            begin
                if (flow == FLOW_XOFF_PENDING)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = CHAR_XOFF;
                    flow = FLOW_XOFF_SENT;
                    n_xoff++;
                end
                else if (flow == FLOW_XON_PENDING)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = CHAR_XON;
                    flow = FLOW_XON_SENT;
                    n_xon++;
                end
                else if (tx_rd != tx_wr && !remote_hold)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = tx_mem[tx_rd];
                    tx_rd = tx_rd + 8'd1;
                end
            end
            CMD_HOST_WRITE:
            begin
                nxt = tx_wr + 8'd1;
                if (!tx_dropped)
                begin
                    if (nxt == tx_rd)
                    begin
                        tx_dropped = 1'b1;
                        n_tx_drop++;
                    end
                    else
                    begin
                        tx_mem[tx_wr] = it.data_byte;
                        tx_wr = nxt;
                    end
                end
            end
            CMD_HOST_READ:
            begin
                fr = rx_rd - rx_wr - 8'd1;
                if (flow == FLOW_XOFF_SENT && fr > thr_xon) flow = FLOW_XON_PENDING;
                if (rx_rd != rx_wr)
                begin
                    r.read_valid = 1'b1;
                    r.read_byte = rx_mem[rx_rd];
                    rx_rd = rx_rd + 8'd1;
                    n_popped++;
                end
            end
            CMD_CLEAR:
            begin
                seen_framing = 1'b0;
                seen_overrun = 1'b0;
                rx_dropped = 1'b0;
                tx_dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.framing_seen = seen_framing;
        r.overrun_seen = seen_overrun;
        r.rx_overflow = rx_dropped;
        r.tx_overflow = tx_dropped;
        r.rx_free = rx_rd - rx_wr - 8'd1;
        r.tx_free = tx_rd - tx_wr - 8'd1;
        r.flow_state = flow;
        r.remote_paused = remote_hold;
        return r;
    endfunction

    function automatic item_t ev(input logic [2:0] cmd, input logic [7:0] data,
                                 input logic fe, input logic oe);
        item_t it;
        it.command = cmd;
        it.data_byte = data;
        it.framing_error = fe;
        it.overrun_error = oe;
        return it;
    endfunction

    // flags: framing, overrun, rx overflow, tx overflow
    function automatic result_t res(input logic txv, input logic [7:0] txb,
                                    input logic rdv, input logic [7:0] rdb,
                                    input logic [3:0] flags, input logic [7:0] rxf,
                                    input logic [7:0] txf, input logic [1:0] fl,
                                    input logic paused);
        result_t r;
        r.tx_valid = txv;
        r.tx_byte = txb;
        r.read_valid = rdv;
        r.read_byte = rdb;
        {r.framing_seen, r.overrun_seen, r.rx_overflow, r.tx_overflow} = flags;
        r.rx_free = rxf;
        r.tx_free = txf;
        r.flow_state = fl;
        r.remote_paused = paused;
        return r;
    endfunction

    function automatic item_t gen_item(input int kind);
        item_t it;
        int    sel;
        it.data_byte = 8'($urandom_range(0, 255));
        it.framing_error = ($urandom_range(0, 7) == 0);
        it.overrun_error = ($urandom_range(0, 7) == 0);
        sel = $urandom_range(0, 31);
        case (kind)
            BURST_RX:    it.command = CMD_RX_BYTE;
            BURST_TXRDY: it.command = CMD_TX_READY;
            BURST_WRITE: it.command = CMD_HOST_WRITE;
            BURST_READ:  it.command = CMD_HOST_READ;
            default:
            begin
                sel = $urandom_range(0, 15);
                if (sel < 5) it.command = CMD_RX_BYTE;
                else if (sel < 8) it.command = CMD_TX_READY;
                else if (sel < 11) it.command = CMD_HOST_WRITE;
                else if (sel < 14) it.command = CMD_HOST_READ;
                else if (sel == 14) it.command = CMD_CLEAR;
                else it.command = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
                sel = $urandom_range(0, 7);
            end
        endcase
        // flow-control characters show up now and then in received data
        if (it.command == CMD_RX_BYTE && sel == 0) it.data_byte = CHAR_XOFF;
        if (it.command == CMD_RX_BYTE && sel == 1) it.data_byte = CHAR_XON;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_event(input item_t it, input bit known, input result_t status);
        int      gap;
        result_t predicted;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_ready !== 1'b1);
        predicted = predict_status(it);
        pending_status.push_back(known ? status : predicted);
        n_events++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // the bus goes idle after each access, which keeps back-to-back accesses apart
    task automatic cfg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [7:0] xoff_thr, input logic [7:0] xon_thr);
        logic [31:0] rd;
        cfg_access(1'b1, {REG_XOFF_THR, 2'b00}, {24'd0, xoff_thr}, rd);
        cfg_access(1'b1, {REG_XON_THR, 2'b00}, {24'd0, xon_thr}, rd);
        thr_xoff = xoff_thr;
        thr_xon = xon_thr;
        cfg_access(1'b0, {REG_XOFF_THR, 2'b00}, '0, rd);
        check_field("xoff_free_threshold", {24'd0, xoff_thr}, rd);
        cfg_access(1'b0, {REG_XON_THR, 2'b00}, '0, rd);
        check_field("xon_free_threshold", {24'd0, xon_thr}, rd);
        n_settings++;
    endtask

    // result side: random stall per transfer, compare with oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_ready)
        begin
            n_results++;
            if (pending_status.size() == 0)
            begin
                $error("result transfer with nothing expected: 0x%0h", result);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("tx_valid", want.tx_valid, result.tx_valid);
                check_field("tx_byte", want.tx_byte, result.tx_byte);
                check_field("read_valid", want.read_valid, result.read_valid);
                check_field("read_byte", want.read_byte, result.read_byte);
                check_field("framing_seen", want.framing_seen, result.framing_seen);
                check_field("overrun_seen", want.overrun_seen, result.overrun_seen);
                check_field("rx_overflow", want.rx_overflow, result.rx_overflow);
                check_field("tx_overflow", want.tx_overflow, result.tx_overflow);
                check_field("rx_free", want.rx_free, result.rx_free);
                check_field("tx_free", want.tx_free, result.tx_free);
                check_field("flow_state", want.flow_state, result.flow_state);
                check_field("remote_paused", want.remote_paused, result.remote_paused);
            end
            stall_left = $urandom_range(0, stall_max);
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        result_ready <= rst_n && (stall_left == 0);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready)
                || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] xoff_set [N_PHASES];
        logic [7:0] xon_set [N_PHASES];
        int         budget;
        int         done;
        int         sel;
        int         kind;
        int         len;
        item_t      it;

        xoff_set = '{XOFF_THR_RESET, 8'd255, 8'd0, 8'd128, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'd1};
        xon_set  = '{XON_THR_RESET, 8'd0, 8'd255, 8'd64, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'd254};

        // after reset, extremes, pause/resume and the xoff/xon round trip
        dir_rows.push_back('{ev(CMD_CLEAR, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_HOST_READ, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'hFF, 1, 1), 1,
                             res(0, 0, 0, 0, 4'b1100, 254, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_RX_BYTE, CHAR_XOFF, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 255, FLOW_XON_SENT, 1)});
        dir_rows.push_back('{ev(CMD_HOST_WRITE, 8'hFF, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 254, FLOW_XON_SENT, 1)});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 254, FLOW_XON_SENT, 1)});
        dir_rows.push_back('{ev(CMD_RX_BYTE, CHAR_XON, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 254, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 1,
                             res(1, 8'hFF, 0, 0, 4'b1100, 253, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_HOST_WRITE, 8'h00, 0, 0), 1,
                             res(0, 0, 0, 0, 4'b1100, 253, 254, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 1,
                             res(1, 8'h00, 0, 0, 4'b1100, 253, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_HOST_READ, 8'h00, 0, 0), 1,
                             res(0, 0, 1, 8'hFF, 4'b1100, 254, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_HOST_READ, 8'h00, 0, 0), 1,
                             res(0, 0, 1, 8'h00, 4'b1100, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_CLEAR, 8'hFF, 1, 1), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_SPARE_5, 8'hFF, 1, 1), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_SPARE_6, 8'hFF, 1, 1), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        dir_rows.push_back('{ev(CMD_SPARE_7, 8'hFF, 1, 1), 1,
                             res(0, 0, 0, 0, 4'b0000, 255, 255, FLOW_XON_SENT, 0)});
        // fill past the xoff threshold, last one a flow character
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'h01, 1, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'hFE, 0, 1), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'h55, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'hAA, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'h7F, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, 8'h80, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_RX_BYTE, CHAR_XON, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_HOST_READ, 8'h00, 0, 0), 0, '0});
        dir_rows.push_back('{ev(CMD_TX_READY, 8'h00, 0, 0), 0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_event(dir_rows[i].ev, dir_rows[i].known, dir_rows[i].status);

        budget = RANDOM_ITEMS / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // thresholds change only with the engine idle
            drain_results();
            set_thresholds(xoff_set[ph], xon_set[ph]);
            done = 0;
            while (done < budget)
            begin
                sel = $urandom_range(0, 15);
                if (sel < 4)
                begin
                    // fill or drain a whole ring
                    kind = sel;
                    len = $urandom_range(256, 290);
                end
                else
                begin
                    kind = $urandom_range(0, 7);
                    if (kind > BURST_MIX) kind = BURST_MIX;
                    len = $urandom_range(1, 24);
                end
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
                if (kind == BURST_WRITE && $urandom_range(0, 1))
                begin
                    send_event(ev(CMD_CLEAR, 8'h00, 0, 0), 0, '0);
                    done++;
                end
                if (len > budget - done) len = budget - done;
                repeat (len)
                begin
                    it = gen_item(kind);
                    send_event(it, 0, '0);
                    done++;
                end
            end
        end

        item_valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
        repeat (4) @(posedge clk);

        $display("%0d events over %0d threshold settings, %0d results checked",
                 n_events, n_settings, n_results);
        $display("xoff sent %0d, xon sent %0d, bytes popped %0d, rx drops %0d, tx drops %0d",
                 n_xoff, n_xon, n_popped, n_rx_drop, n_tx_drop);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
sv/urbx_pkg.sv
sv/urbx_ring.sv
sv/uart_ring_buffers_xon_xoff.sv
tb/sv/tb_top.sv
